// ===== hw/rtl/ssst_pkg.sv =====
// ----------------------------------------------------------------------------
// ssst_pkg: shared constants and tables of the spike-and-slab soft threshold
// Defaults, fixed-point constants, register indexes and the exp root table.
// ----------------------------------------------------------------------------
package ssst_pkg;

   localparam int FRAC_BITS_DEF      = 16;
   localparam int EXP_TABLE_BITS_DEF = 8;

   // Q1.16 one and log2(e) in Q1.16
   localparam logic [16:0] ONE_Q16   = 17'd65536;
   localparam logic [16:0] LOG2E_Q16 = 17'd94548;
   localparam logic [15:0] HALF_Q16  = 16'd32768;

   // exponent at which 2^(-u) is flushed to zero
   localparam logic [6:0]  EXP_K_MAX = 7'd17;

   // register file
   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_SLAB_WEIGHT    = 3'd0;
   localparam csr_index_type CSR_SPIKE_PENALTY  = 3'd1;
   localparam csr_index_type CSR_SLAB_PENALTY   = 3'd2;
   localparam csr_index_type CSR_GRAM_NORM      = 3'd3;
   localparam csr_index_type CSR_KEEP_THRESHOLD = 3'd4;

   localparam logic [16:0] RST_SLAB_WEIGHT    = 17'd32768;
   localparam logic [30:0] RST_SPIKE_PENALTY  = 31'd65536;
   localparam logic [30:0] RST_SLAB_PENALTY   = 31'd65536;
   localparam logic [30:0] RST_GRAM_NORM      = 31'd65536;
   localparam logic [30:0] RST_KEEP_THRESHOLD = 31'd0;

   // 2^(-2^-(i+1)) in Q0.16
   function automatic logic [15:0] root_q16(input int unsigned i);
      logic [15:0] r;
      case (i)
         0:       r = 16'd46341;
         1:       r = 16'd55110;
         2:       r = 16'd60098;
         3:       r = 16'd62757;
         4:       r = 16'd64132;
         5:       r = 16'd64830;
         6:       r = 16'd65182;
         7:       r = 16'd65359;
         8:       r = 16'd65447;
         9:       r = 16'd65492;
         10:      r = 16'd65514;
         11:      r = 16'd65525;
         default: r = 16'hFFFF;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/ssst_div.sv =====
// ----------------------------------------------------------------------------
// ssst_div: pipelined restoring divider
// One quotient bit per stage, one item per enabled cycle, sideband alongside.
// ----------------------------------------------------------------------------
module ssst_div #(
   parameter int NUM_W  = 64,
   parameter int DEN_W  = 49,
   parameter int QUO_W  = 17,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   localparam int CMP_W = (NUM_W > DEN_W + QUO_W - 1) ? NUM_W : DEN_W + QUO_W - 1;

   logic [NUM_W-1:0]  rem_ff  [QUO_W];
   logic [DEN_W-1:0]  den_ff  [QUO_W];
   logic [QUO_W-1:0]  quo_ff  [QUO_W];
   logic [SIDE_W-1:0] side_ff [QUO_W];
   logic              vld_ff  [QUO_W];

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      localparam int BIT = QUO_W - 1 - s;
      logic [NUM_W-1:0]  rem_src;
      logic [DEN_W-1:0]  den_src;
      logic [QUO_W-1:0]  quo_src;
      logic [SIDE_W-1:0] side_src;
      logic              vld_src;
      logic [CMP_W-1:0]  sub_w;
      logic [CMP_W-1:0]  rem_w;
      logic [NUM_W-1:0]  rem_in;
      logic [QUO_W-1:0]  quo_in;

      if (s == 0) begin : g_first
         assign rem_src  = in_num;
         assign den_src  = in_den;
         assign quo_src  = '0;
         assign side_src = in_side;
         assign vld_src  = in_valid;
      end else begin : g_next
         assign rem_src  = rem_ff[s-1];
         assign den_src  = den_ff[s-1];
         assign quo_src  = quo_ff[s-1];
         assign side_src = side_ff[s-1];
         assign vld_src  = vld_ff[s-1];
      end

      always_comb begin
         sub_w  = CMP_W'(den_src) << BIT;
         rem_w  = CMP_W'(rem_src);
         rem_in = rem_src;
         quo_in = quo_src;
         if (rem_w >= sub_w) begin
            rem_in      = NUM_W'(rem_w - sub_w);
            quo_in[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (enable) begin
            vld_ff[s] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s]  <= rem_in;
            den_ff[s]  <= den_src;
            quo_ff[s]  <= quo_in;
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

// ===== hw/rtl/ssst_exp.sv =====
// ----------------------------------------------------------------------------
// ssst_exp: two-lane pipelined exp(-t)
// exp(-t) = 2^(-u); fraction bits walk a root table, one multiply per stage.
// ----------------------------------------------------------------------------
module ssst_exp #(
   parameter int FRAC_BITS = ssst_pkg::FRAC_BITS_DEF,
   parameter int TAB_BITS  = ssst_pkg::EXP_TABLE_BITS_DEF,
   parameter int T_W       = 47,
   parameter int SIDE_W    = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic [T_W-1:0]    in_t0,
   input  logic [T_W-1:0]    in_t1,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [16:0]       out_e0,
   output logic [16:0]       out_e1,
   output logic [SIDE_W-1:0] out_side
);

   localparam int TC_W = FRAC_BITS + 6;
   localparam int P_W  = TC_W + 17;
   localparam int U_W  = P_W - 16;
   localparam int FX_W = FRAC_BITS + TAB_BITS;
   localparam logic [T_W-1:0] LIMIT = T_W'(32) << FRAC_BITS;

   logic [T_W-1:0]      t_w    [2];
   logic [TC_W-1:0]     tc_w   [2];
   logic [P_W-1:0]      prod_w [2];
   logic [U_W-1:0]      u_w    [2];
   logic [FX_W-1:0]     fx_w   [2];

   logic [16:0]         acc_ff  [TAB_BITS+1][2];
   logic [TAB_BITS-1:0] idx_ff  [TAB_BITS+1][2];
   logic [6:0]          k_ff    [TAB_BITS+1][2];
   logic [SIDE_W-1:0]   side_ff [TAB_BITS+1];
   logic                vld_ff  [TAB_BITS+1];

   logic [16:0]         e_in    [2];
   logic [16:0]         e_ff    [2];
   logic [SIDE_W-1:0]   eside_ff;
   logic                evld_ff;

   assign t_w[0] = in_t0;
   assign t_w[1] = in_t1;

   // clamp, scale by log2(e), split into integer and fraction
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         tc_w[l]   = (t_w[l] > LIMIT) ? LIMIT[TC_W-1:0] : t_w[l][TC_W-1:0];
         prod_w[l] = P_W'(tc_w[l]) * P_W'(ssst_pkg::LOG2E_Q16);
         u_w[l]    = prod_w[l][P_W-1:16];
         fx_w[l]   = {u_w[l][FRAC_BITS-1:0], {TAB_BITS{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int l = 0; l < 2; l++) begin
            acc_ff[0][l] <= ssst_pkg::ONE_Q16;
            idx_ff[0][l] <= fx_w[l][FX_W-1:FRAC_BITS];
            k_ff[0][l]   <= 7'(u_w[l][U_W-1:FRAC_BITS]);
         end
         side_ff[0] <= in_side;
      end
   end

   for (genvar i = 0; i < TAB_BITS; i++) begin : g_root
      localparam logic [15:0] ROOT = ssst_pkg::root_q16(i);
      logic [33:0] mul_w [2];
      logic [16:0] acc_in [2];

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            mul_w[l]  = 34'(acc_ff[i][l]) * 34'(ROOT) + 34'(ssst_pkg::HALF_Q16);
            acc_in[l] = idx_ff[i][l][TAB_BITS-1-i] ? mul_w[l][32:16] : acc_ff[i][l];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (enable) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            for (int l = 0; l < 2; l++) begin
               acc_ff[i+1][l] <= acc_in[l];
               idx_ff[i+1][l] <= idx_ff[i][l];
               k_ff[i+1][l]   <= k_ff[i][l];
            end
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   // apply the integer exponent, flush to zero at large k
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         if (k_ff[TAB_BITS][l] >= ssst_pkg::EXP_K_MAX) begin
            e_in[l] = '0;
         end else begin
            e_in[l] = acc_ff[TAB_BITS][l] >> k_ff[TAB_BITS][l][4:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         evld_ff <= 1'b0;
      end else if (enable) begin
         evld_ff <= vld_ff[TAB_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         e_ff[0]  <= e_in[0];
         e_ff[1]  <= e_in[1];
         eside_ff <= side_ff[TAB_BITS];
      end
   end

   assign out_valid = evld_ff;
   assign out_e0    = e_ff[0];
   assign out_e1    = e_ff[1];
   assign out_side  = eside_ff;

endmodule

// ===== hw/rtl/spike_slab_soft_threshold.sv =====
// ----------------------------------------------------------------------------
// spike_slab_soft_threshold: adaptive spike-and-slab soft thresholding
// Per coefficient: Laplace mixture penalty, soft threshold, keep mask, scale.
// ----------------------------------------------------------------------------
// The block takes one coefficient item per clock unless the output stalls,
// and returns one result item per input, in order. Throughput is then one
// item per cycle: every step is a register stage, the two exp lanes use one
// table multiply per stage and both divisions are restoring dividers with
// one quotient bit per stage. It is built from input and penalty stages, the
// exp pipe (EXP_TABLE_BITS + 2), density weighting, the 17-stage mixing
// divider, five penalty and mask stages, the 33-stage scaling divider and the
// output register. When the result is not taken the whole pipe holds, so no
// item is lost or repeated. Write the registers only while the pipe is empty.
// ----------------------------------------------------------------------------
module spike_slab_soft_threshold #(
   parameter int FRAC_BITS      = ssst_pkg::FRAC_BITS_DEF,
   parameter int EXP_TABLE_BITS = ssst_pkg::EXP_TABLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] current_coef, [63:32] residual_sum
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] new_coef, [62:32] applied_penalty, [63] zero
   output logic [0:0]  rsp_tuser,   // [0] survived
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [30:0] csr_wdata
);

   localparam int T_W  = 63 - FRAC_BITS;
   localparam int D_W  = 32 + FRAC_BITS;
   localparam int XS_W = 33;
   localparam int P1_W = 34;
   localparam int P2_W = 34;

   // ---------------- configuration registers ----------------
   logic [16:0] slab_weight_ff;
   logic [30:0] spike_ff, slab_ff, gram_ff, keep_ff;
   logic [16:0] rho;

   always_ff @(posedge clock) begin
      if (reset) begin
         slab_weight_ff <= ssst_pkg::RST_SLAB_WEIGHT;
         spike_ff       <= ssst_pkg::RST_SPIKE_PENALTY;
         slab_ff        <= ssst_pkg::RST_SLAB_PENALTY;
         gram_ff        <= ssst_pkg::RST_GRAM_NORM;
         keep_ff        <= ssst_pkg::RST_KEEP_THRESHOLD;
      end else if (csr_we) begin
         case (csr_index)
            ssst_pkg::CSR_SLAB_WEIGHT:    slab_weight_ff <= csr_wdata[16:0];
            ssst_pkg::CSR_SPIKE_PENALTY:  spike_ff       <= csr_wdata;
            ssst_pkg::CSR_SLAB_PENALTY:   slab_ff        <= csr_wdata;
            ssst_pkg::CSR_GRAM_NORM:      gram_ff        <= csr_wdata;
            ssst_pkg::CSR_KEEP_THRESHOLD: keep_ff        <= csr_wdata;
            default: ;   // drop writes beyond the register list
         endcase
      end
   end

   // clamp the slab weight to one
   assign rho = (slab_weight_ff > ssst_pkg::ONE_Q16) ? ssst_pkg::ONE_Q16 : slab_weight_ff;

   // ---------------- flow control ----------------
   // advance the whole pipe whenever the output register can move
   logic adv;
   logic rsp_valid_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // ---------------- stage a: magnitudes ----------------
   logic [31:0] coef_w, sum_w, ax_in, az_in;
   logic        a_vld_ff;
   logic [31:0] ax_a_ff, az_a_ff;
   logic        zneg_a_ff;

   assign coef_w = req_tdata[31:0];
   assign sum_w  = req_tdata[63:32];
   assign ax_in  = coef_w[31] ? (~coef_w + 32'd1) : coef_w;
   assign az_in  = sum_w[31]  ? (~sum_w + 32'd1)  : sum_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ax_a_ff   <= ax_in;
         az_a_ff   <= az_in;
         zneg_a_ff <= sum_w[31];
      end
   end

   // ---------------- stage b: exponent arguments ----------------
   logic [62:0]    t0_prod, t1_prod;
   logic           b_vld_ff;
   logic [T_W-1:0] t0_b_ff, t1_b_ff;
   logic [31:0]    az_b_ff;
   logic           zneg_b_ff;

   assign t0_prod = 63'(spike_ff) * 63'(ax_a_ff);
   assign t1_prod = 63'(slab_ff) * 63'(ax_a_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t0_b_ff   <= t0_prod[62:FRAC_BITS];
         t1_b_ff   <= t1_prod[62:FRAC_BITS];
         az_b_ff   <= az_a_ff;
         zneg_b_ff <= zneg_a_ff;
      end
   end

   // ---------------- exp pipe ----------------
   logic              x_vld;
   logic [16:0]       e0_x, e1_x;
   logic [XS_W-1:0]   side_x;

   ssst_exp #(
      .FRAC_BITS (FRAC_BITS),
      .TAB_BITS  (EXP_TABLE_BITS),
      .T_W       (T_W),
      .SIDE_W    (XS_W)
   ) u_exp (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (b_vld_ff),
      .in_t0     (t0_b_ff),
      .in_t1     (t1_b_ff),
      .in_side   ({zneg_b_ff, az_b_ff}),
      .out_valid (x_vld),
      .out_e0    (e0_x),
      .out_e1    (e1_x),
      .out_side  (side_x)
   );

   // ---------------- stage c: weight the densities ----------------
   logic [33:0]     p0_prod, p1_prod;
   logic            c_vld_ff;
   logic [16:0]     p0_c_ff, p1_c_ff;
   logic [XS_W-1:0] side_c_ff;

   assign p0_prod = 34'(ssst_pkg::ONE_Q16 - rho) * 34'(e0_x);
   assign p1_prod = 34'(rho) * 34'(e1_x);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= x_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_c_ff   <= p0_prod[32:16];
         p1_c_ff   <= p1_prod[32:16];
         side_c_ff <= side_x;
      end
   end

   // ---------------- stage d: times the rates ----------------
   logic [47:0]     w0_in, w1_in;
   logic            d_vld_ff;
   logic [47:0]     w0_d_ff, w1_d_ff;
   logic [XS_W-1:0] side_d_ff;

   assign w0_in = 48'(p0_c_ff) * 48'(spike_ff);
   assign w1_in = 48'(p1_c_ff) * 48'(slab_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (adv) begin
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w0_d_ff   <= w0_in;
         w1_d_ff   <= w1_in;
         side_d_ff <= side_c_ff;
      end
   end

   // ---------------- stage e: mixture total ----------------
   logic            e_vld_ff;
   logic [48:0]     tot_e_ff;
   logic [47:0]     w1_e_ff;
   logic            zero_e_ff;
   logic [XS_W-1:0] side_e_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (adv) begin
         e_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tot_e_ff  <= 49'(w0_d_ff) + 49'(w1_d_ff);
         w1_e_ff   <= w1_d_ff;
         zero_e_ff <= (w0_d_ff == '0) && (w1_d_ff == '0);
         side_e_ff <= side_d_ff;
      end
   end

   // ---------------- mixing divider: pstar ----------------
   logic            q1_vld;
   logic [16:0]     q1_quo;
   logic [P1_W-1:0] q1_side;

   ssst_div #(
      .NUM_W  (64),
      .DEN_W  (49),
      .QUO_W  (17),
      .SIDE_W (P1_W)
   ) u_div_mix (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (e_vld_ff),
      .in_num    ({w1_e_ff, 16'd0}),
      .in_den    (tot_e_ff),
      .in_side   ({zero_e_ff, side_e_ff}),
      .out_valid (q1_vld),
      .out_quo   (q1_quo),
      .out_side  (q1_side)
   );

   // ---------------- stage f: pstar with empty-mixture fallback ----------------
   logic [16:0]     pstar_fb, pstar_in;
   logic            f_vld_ff;
   logic [16:0]     pstar_f_ff;
   logic [XS_W-1:0] side_f_ff;

   always_comb begin
      if (rho == '0) begin
         pstar_fb = '0;
      end else if (rho == ssst_pkg::ONE_Q16) begin
         pstar_fb = ssst_pkg::ONE_Q16;
      end else if (slab_ff < spike_ff) begin
         pstar_fb = ssst_pkg::ONE_Q16;
      end else if (slab_ff > spike_ff) begin
         pstar_fb = '0;
      end else begin
         pstar_fb = rho;
      end
      pstar_in = q1_side[P1_W-1] ? pstar_fb : q1_quo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (adv) begin
         f_vld_ff <= q1_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pstar_f_ff <= pstar_in;
         side_f_ff  <= q1_side[XS_W-1:0];
      end
   end

   // ---------------- stage g: penalty products ----------------
   logic            g_vld_ff;
   logic [47:0]     m0_g_ff, m1_g_ff;
   logic [XS_W-1:0] side_g_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else if (adv) begin
         g_vld_ff <= f_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m0_g_ff   <= 48'(spike_ff) * 48'(ssst_pkg::ONE_Q16 - pstar_f_ff);
         m1_g_ff   <= 48'(slab_ff) * 48'(pstar_f_ff);
         side_g_ff <= side_f_ff;
      end
   end

   // ---------------- stage h: penalty and keep mask ----------------
   logic [48:0]     pen_sum;
   logic            h_vld_ff;
   logic [30:0]     pen_h_ff;
   logic            keep_h_ff;
   logic [XS_W-1:0] side_h_ff;

   assign pen_sum = 49'(m0_g_ff) + 49'(m1_g_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         h_vld_ff <= 1'b0;
      end else if (adv) begin
         h_vld_ff <= g_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pen_h_ff  <= pen_sum[46:16];
         keep_h_ff <= side_g_ff[31:0] > 32'(keep_ff);
         side_h_ff <= side_g_ff;
      end
   end

   // ---------------- stage i: shrink by the penalty ----------------
   logic        i_vld_ff;
   logic [31:0] diff_i_ff;
   logic [30:0] pen_i_ff;
   logic        keep_i_ff, live_i_ff, zneg_i_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         i_vld_ff <= 1'b0;
      end else if (adv) begin
         i_vld_ff <= h_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         diff_i_ff <= side_h_ff[31:0] - 32'(pen_h_ff);
         live_i_ff <= keep_h_ff && (gram_ff != '0) && (side_h_ff[31:0] > 32'(pen_h_ff));
         pen_i_ff  <= pen_h_ff;
         keep_i_ff <= keep_h_ff;
         zneg_i_ff <= side_h_ff[32];
      end
   end

   // ---------------- stage j: quotient overflow check ----------------
   logic            j_vld_ff;
   logic [D_W-1:0]  num_j_ff;
   logic            ovf_j_ff;
   logic [P2_W-1:0] side_j_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         j_vld_ff <= 1'b0;
      end else if (adv) begin
         j_vld_ff <= i_vld_ff;
      end
   end

   // a quotient of 2^33 or more saturates in any case
   always_ff @(posedge clock) begin
      if (adv) begin
         num_j_ff  <= {diff_i_ff, {FRAC_BITS{1'b0}}};
         ovf_j_ff  <= 64'({diff_i_ff, {FRAC_BITS{1'b0}}}) >= {gram_ff, 33'd0};
         side_j_ff <= {pen_i_ff, keep_i_ff, live_i_ff, zneg_i_ff};
      end
   end

   // ---------------- scaling divider ----------------
   logic            q2_vld;
   logic [32:0]     q2_quo;
   logic [P2_W:0]   q2_side;

   ssst_div #(
      .NUM_W  (D_W),
      .DEN_W  (31),
      .QUO_W  (33),
      .SIDE_W (P2_W + 1)
   ) u_div_scale (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (j_vld_ff),
      .in_num    (num_j_ff),
      .in_den    (gram_ff),
      .in_side   ({side_j_ff, ovf_j_ff}),
      .out_valid (q2_vld),
      .out_quo   (q2_quo),
      .out_side  (q2_side)
   );

   // ---------------- output stage: saturate, sign, register ----------------
   logic        ovf_o, zneg_o, live_o, keep_o;
   logic [30:0] pen_o;
   logic [31:0] mag_o, coef_o;
   logic [62:0] rsp_data_ff;
   logic        rsp_user_ff;

   assign ovf_o  = q2_side[0];
   assign zneg_o = q2_side[1];
   assign live_o = q2_side[2];
   assign keep_o = q2_side[3];
   assign pen_o  = q2_side[P2_W:4];

   always_comb begin
      if (zneg_o) begin
         mag_o  = (ovf_o || q2_quo > 33'h080000000) ? 32'h80000000 : q2_quo[31:0];
         coef_o = ~mag_o + 32'd1;
      end else begin
         mag_o  = (ovf_o || q2_quo > 33'h07FFFFFFF) ? 32'h7FFFFFFF : q2_quo[31:0];
         coef_o = mag_o;
      end
      if (!live_o) begin
         coef_o = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= q2_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= {pen_o, coef_o};
         rsp_user_ff <= keep_o;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {1'b0, rsp_data_ff};
   assign rsp_tuser[0] = rsp_user_ff;

   // ---------------- assertions ----------------
   // a dropped element never carries a coefficient
   a_drop_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_user_ff) |-> (rsp_data_ff[31:0] == '0))
      else $error("non-surviving item with nonzero coefficient");

   // a nonzero coefficient needs a nonzero divisor
   a_gram_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[31:0] != '0) |-> (gram_ff != '0))
      else $error("coefficient produced with zero gram norm");

   // the mixed penalty is not above both rates
   a_pen_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff[62:32] <= spike_ff) || (rsp_data_ff[62:32] <= slab_ff)))
      else $error("applied penalty above both rates");

   // a stalled result is held while the pipe is frozen
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("stalled result changed");

endmodule

// ===== dv/tb_spike_slab_soft_threshold.sv =====
// ----------------------------------------------------------------------------
// tb_spike_slab_soft_threshold: stream test of the adaptive soft threshold
// Drives coefficient items with random idling on both sides and compares
// each result item against a bit-accurate predictor of the penalty mixing,
// soft threshold, keep mask and Gram-norm scaling, under several settings.
// ----------------------------------------------------------------------------
module tb_spike_slab_soft_threshold;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          LATENCY   = 71;
   localparam int          WDOG_MAX  = 2000;
   localparam logic [31:0] ROOTS [12] = '{46341, 55110, 60098, 62757, 64132, 64830,
                                          65182, 65359, 65447, 65492, 65514, 65525};

   typedef struct packed {
      logic [31:0] coef;
      logic [30:0] pen;
      logic        keep;
   } thresh_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [30:0] csr_wdata = '0;

   // shadow copy of the register file
   logic [16:0] rho_reg;
   logic [30:0] l0_reg, l1_reg, gram_reg, keep_reg;

   thresh_result_type expected_q[$];
   int  errors = 0;
   int  n_sent = 0;
   int  n_recv = 0;
   int  n_kept = 0;
   int  wdog   = 0;
   bit  calm   = 1'b0;   // no idling in the last part of the run

   spike_slab_soft_threshold i_dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // 2^(-u) exp approximation: exp(-t), t in Q16.16, result Q1.16
   function automatic logic [63:0] exp_neg_q16(input logic [63:0] t);
      logic [63:0] u, k, idx, acc;
      acc = 64'd65536;
      if (t > (64'd32 << 16)) t = 64'd32 << 16;
      u = (t * 64'd94548) >> 16;
      k = u >> 16;
      if (k >= 64'd17) return 64'd0;
      idx = ((u & 64'hFFFF) << 8) >> 16;
      for (int i = 0; i < 8; i++) begin
         if (idx[7-i]) acc = (acc * ROOTS[i] + 64'd32768) >> 16;
      end
      return acc >> k;
   endfunction

   function automatic thresh_result_type soft_threshold(input logic [31:0] x,
                                                       input logic [31:0] z);
      thresh_result_type r;
      logic [63:0] ax, az, rho, l0, l1, w0, w1, pstar, pen, mag;
      ax  = x[31] ? 64'h1_0000_0000 - x : {32'd0, x};
      az  = z[31] ? 64'h1_0000_0000 - z : {32'd0, z};
      rho = (rho_reg > 17'd65536) ? 64'd65536 : rho_reg;
      l0  = l0_reg;
      l1  = l1_reg;
      w0  = (((64'd65536 - rho) * exp_neg_q16((l0 * ax) >> 16)) >> 16) * l0;
      w1  = ((rho * exp_neg_q16((l1 * ax) >> 16)) >> 16) * l1;
      // both weights vanish: fall back on the prior, then on the rate order
      if (w0 + w1 != 0)        pstar = (w1 << 16) / (w0 + w1);
      else if (rho == 0)       pstar = 0;
      else if (rho == 65536)   pstar = 65536;
      else if (l1 < l0)        pstar = 65536;
      else if (l1 > l0)        pstar = 0;
      else                     pstar = rho;
      pen    = (l0 * (64'd65536 - pstar) + l1 * pstar) >> 16;
      r.pen  = pen[30:0];
      r.keep = az > keep_reg;
      r.coef = '0;
      if (r.keep && gram_reg != 0 && az > pen) begin
         mag = ((az - pen) << 16) / gram_reg;
         if (z[31]) begin
            if (mag > 64'h8000_0000) mag = 64'h8000_0000;
            r.coef = 32'(64'h1_0000_0000 - mag);
         end else begin
            if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
            r.coef = mag[31:0];
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      $display("MISMATCH item %0d %s: got %h want %h", n_recv, what, got, want);
   endtask

   // check every accepted result against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata[31:0], '0);
         end else begin
            thresh_result_type e;
            e = expected_q.pop_front();
            if (rsp_tdata[31:0] !== e.coef)
               report_mismatch("new_coef", rsp_tdata[31:0], e.coef);
            if (rsp_tdata[62:32] !== e.pen)
               report_mismatch("applied_penalty", {1'b0, rsp_tdata[62:32]}, {1'b0, e.pen});
            if (rsp_tuser[0] !== e.keep)
               report_mismatch("survived", {31'd0, rsp_tuser[0]}, {31'd0, e.keep});
            if (e.keep) n_kept++;
         end
         n_recv++;
      end
   end

   // receiver: stall in random bursts unless in the calm tail
   initial begin
      int gap;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // watchdog: count cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) wdog <= 0;
      else if (!reset) wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
         $display("watchdog expired: sent %0d, received %0d", n_sent, n_recv);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // send one item, holding tvalid across back-to-back items
   task automatic send_item(input logic [31:0] x, input logic [31:0] z);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 11);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {z, x};
      expected_q.push_back(soft_threshold(x, z));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // one write strobe; the enable is low again when the task returns
   task automatic write_reg(input ssst_pkg::csr_index_type idx, input logic [30:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         ssst_pkg::CSR_SLAB_WEIGHT:    rho_reg  = val[16:0];
         ssst_pkg::CSR_SPIKE_PENALTY:  l0_reg   = val;
         ssst_pkg::CSR_SLAB_PENALTY:   l1_reg   = val;
         ssst_pkg::CSR_GRAM_NORM:      gram_reg = val;
         ssst_pkg::CSR_KEEP_THRESHOLD: keep_reg = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_all(input logic [16:0] rho, input logic [30:0] l0, l1, g, k);
      write_reg(ssst_pkg::CSR_SLAB_WEIGHT, {14'd0, rho});
      write_reg(ssst_pkg::CSR_SPIKE_PENALTY, l0);
      write_reg(ssst_pkg::CSR_SLAB_PENALTY, l1);
      write_reg(ssst_pkg::CSR_GRAM_NORM, g);
      write_reg(ssst_pkg::CSR_KEEP_THRESHOLD, k);
   endtask

   // mostly moderate values, some full-range ones
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return 32'($signed($urandom_range(0, 24'hFFFFFF)) - 32'sh800000);
         2:       return 32'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
         default: return 32'($signed($urandom_range(0, 16'hFFFF)) - 32'sh8000);
      endcase
   endfunction

   task automatic test_directed();
      logic [31:0] edges [6] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                 32'h8000_0000, 32'h0001_0000};
      foreach (edges[i]) send_item(edges[i], edges[(i + 2) % 6]);
      drain();
      // zero gram norm, no prior weight, keep level of one half
      set_all(17'd0, 31'd65536, 31'd131072, 31'd0, 31'd32768);
      send_item(32'h0002_0000, 32'h0004_0000);
      send_item(32'hFFF0_0000, 32'hFFFF_0000);
      drain();
      // weights above one, both rates large so both exps flush, equal rates
      set_all(17'h1FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd1, 31'd0);
      send_item(32'h7FFF_FFFF, 32'h8000_0000);
      send_item(32'h0100_0000, 32'h7FFF_FFFF);
      drain();
      // flushed weights with unequal rates, both orders, rho between
      set_all(17'd20000, 31'h4000_0000, 31'h7FFF_FFFF, 31'd1, 31'd0);
      send_item(32'h4000_0000, 32'h0000_1234);
      drain();
      set_all(17'd20000, 31'h7FFF_FFFF, 31'h4000_0000, 31'd65536, 31'h7FFF_FFFF);
      send_item(32'h4000_0000, 32'h8000_0000);
      send_item(32'h0, 32'h7FFF_FFFF);
      drain();
      // zero rates, full slab weight, threshold edge
      set_all(17'd65536, 31'd0, 31'd0, 31'd65536, 31'd100);
      send_item(32'd5, 32'd100);
      send_item(32'd5, 32'd101);
      send_item(32'd5, -32'sd101);
      drain();
      // register index out of range is ignored
      write_reg(3'd5, 31'h7FFF_FFFF);
      write_reg(3'd7, 31'h0);
   endtask

   task automatic test_random_phase(input int n_items);
      set_all($urandom_range(0, 3) == 0 ? 17'($urandom) : 17'($urandom_range(0, 65536)),
              31'($urandom_range(0, 1 << 20)), 31'($urandom_range(0, 1 << 20)),
              $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(1, 1 << 18)),
              $urandom_range(0, 2) == 0 ? 31'($urandom) : 31'($urandom_range(0, 1 << 17)));
      repeat (n_items) send_item(pick_value(), pick_value());
      drain();
   endtask

   initial begin
      // registers come out of reset with their defaults
      rho_reg  = ssst_pkg::RST_SLAB_WEIGHT;
      l0_reg   = ssst_pkg::RST_SPIKE_PENALTY;
      l1_reg   = ssst_pkg::RST_SLAB_PENALTY;
      gram_reg = ssst_pkg::RST_GRAM_NORM;
      keep_reg = ssst_pkg::RST_KEEP_THRESHOLD;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      for (int p = 0; p < 10; p++) test_random_phase(50);
      calm = 1'b1;
      test_random_phase(40);
      $display("covered %0d items over 11 random settings plus edge cases", n_sent);
      $display("%0d results checked, %0d survived the keep threshold", n_recv, n_kept);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/ssst_pkg.sv
hw/rtl/ssst_div.sv
hw/rtl/ssst_exp.sv
hw/rtl/spike_slab_soft_threshold.sv
dv/tb_spike_slab_soft_threshold.sv
